// File: sv/fltpm_pkg.sv
// Shared types and constants for the four-level page table mapper.
// No dependencies; used by the controller, the datapath and the top level.
package fltpm_pkg;

    localparam int POOL_TABLES_DEF = 64;
    localparam int IDX_W           = 9;
    localparam int ENTRY_W         = 64;
    localparam int FRAME_W         = 40;
    localparam int FLAGS_W         = 12;
    localparam int VA_W            = 48;
    localparam int PAGE_SHIFT      = 12;
    localparam int SH_L0           = 39;
    localparam int SH_L1           = 30;
    localparam int SH_L2           = 21;
    localparam int SH_L3           = 12;

    // request modes
    localparam logic [1:0] MODE_MAP   = 2'd0;
    localparam logic [1:0] MODE_COPY  = 2'd1;
    localparam logic [1:0] MODE_FREE  = 2'd2;
    localparam logic [1:0] MODE_ALLOC = 2'd3;

    // result status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_EXHAUST = 2'd1;
    localparam logic [1:0] ST_BAD_IDX = 2'd2;
    localparam logic [1:0] ST_OUTSIDE = 2'd3;

    // memory address sources
    localparam logic [1:0] ADDR_WALK = 2'd0;  // {cur, index of level}
    localparam logic [1:0] ADDR_TBL  = 2'd1;  // {taken table, counter}
    localparam logic [1:0] ADDR_KRN  = 2'd2;  // {kernel root, counter}

    // memory write data sources
    localparam logic [1:0] WD_ZERO  = 2'd0;
    localparam logic [1:0] WD_TABLE = 2'd1;
    localparam logic [1:0] WD_LEAF  = 2'd2;
    localparam logic [1:0] WD_COPY  = 2'd3;

    localparam logic [ENTRY_W-1:0] BIT_PRESENT = 64'h1;
    localparam logic [ENTRY_W-1:0] BIT_WRITE   = 64'h2;

    typedef struct packed {
        logic       load_in;
        logic       mem_re;
        logic       mem_we;
        logic [1:0] addr_sel;
        logic [1:0] wd_sel;
        logic       cnt_inc;
        logic       scan_inc;
        logic       take;
        logic       free;
        logic       walk_init;
        logic       cur_off;
        logic       cur_t;
        logic       lvl_inc;
        logic       added_inc;
        logic       set_st;
        logic [1:0] st_code;
        logic       res_load;
    } cmd_t;

    typedef struct packed {
        logic [1:0] mode;
        logic       tid_bad;
        logic       kroot_bad;
        logic       present;
        logic       off_bad;
        logic       scan_free;
        logic       scan_last;
        logic       scan_is_kroot;
        logic       cnt_last;
        logic       lvl_two;
        logic       out_busy;
    } sts_t;

endpackage

// File: sv/fltpm_ctrl.sv
// Sequencing state machine of the page table mapper.
// Depends on fltpm_pkg; drives fltpm_dp through cmd_t and watches sts_t.
module fltpm_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  fltpm_pkg::sts_t  sts,
    output fltpm_pkg::cmd_t  cmd
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_DISP = 4'd1;
    localparam logic [3:0] S_RD   = 4'd2;
    localparam logic [3:0] S_EVAL = 4'd3;
    localparam logic [3:0] S_SCAN = 4'd4;
    localparam logic [3:0] S_CLR  = 4'd5;
    localparam logic [3:0] S_INST = 4'd6;
    localparam logic [3:0] S_LEAF = 4'd7;
    localparam logic [3:0] S_CPRD = 4'd8;
    localparam logic [3:0] S_CPWR = 4'd9;
    localparam logic [3:0] S_FIN  = 4'd10;

    logic [3:0] state_reg, state_next;
    logic       in_fire;

    assign in_ready = (state_reg == S_IDLE);
    assign in_fire  = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_DISP;
                end
            end
            S_DISP:
            begin
                cmd.walk_init = 1'b1;
                unique case (sts.mode)
                    fltpm_pkg::MODE_MAP:
                    begin
                        if (sts.tid_bad)
                        begin
                            cmd.set_st  = 1'b1;
                            cmd.st_code = fltpm_pkg::ST_BAD_IDX;
                            state_next  = S_FIN;
                        end
                        else
                            state_next = S_RD;
                    end
                    fltpm_pkg::MODE_COPY:
                    begin
                        if (sts.kroot_bad)
                        begin
                            cmd.set_st  = 1'b1;
                            cmd.st_code = fltpm_pkg::ST_BAD_IDX;
                            state_next  = S_FIN;
                        end
                        else
                            state_next = S_SCAN;
                    end
                    fltpm_pkg::MODE_FREE:
                    begin
                        cmd.set_st  = 1'b1;
                        cmd.free    = !sts.tid_bad;
                        cmd.st_code = sts.tid_bad ? fltpm_pkg::ST_BAD_IDX : fltpm_pkg::ST_OK;
                        state_next  = S_FIN;
                    end
                    default:
                        state_next = S_SCAN;
                endcase
            end
            S_RD:
            begin
                cmd.mem_re   = 1'b1;
                cmd.addr_sel = fltpm_pkg::ADDR_WALK;
                state_next   = S_EVAL;
            end
            S_EVAL:
            begin
                if (!sts.present)
                    state_next = S_SCAN;
                else if (sts.off_bad)
                begin
                    cmd.set_st  = 1'b1;
                    cmd.st_code = fltpm_pkg::ST_OUTSIDE;
                    state_next  = S_FIN;
                end
                else
                begin
                    cmd.cur_off = 1'b1;
                    cmd.lvl_inc = 1'b1;
                    state_next  = sts.lvl_two ? S_LEAF : S_RD;
                end
            end
            S_SCAN:
            begin
                priority if (sts.scan_free)
                begin
                    cmd.take = 1'b1;
                    if (sts.mode != fltpm_pkg::MODE_COPY)
                        state_next = S_CLR;
                    else if (sts.scan_is_kroot)
                    begin
                        cmd.set_st  = 1'b1;
                        cmd.st_code = fltpm_pkg::ST_OK;
                        state_next  = S_FIN;
                    end
                    else
                        state_next = S_CPRD;
                end
                else if (sts.scan_last)
                begin
                    cmd.set_st  = 1'b1;
                    cmd.st_code = fltpm_pkg::ST_EXHAUST;
                    state_next  = S_FIN;
                end
                else
                    cmd.scan_inc = 1'b1;
            end
            S_CLR:
            begin
                cmd.mem_we   = 1'b1;
                cmd.addr_sel = fltpm_pkg::ADDR_TBL;
                cmd.wd_sel   = fltpm_pkg::WD_ZERO;
                cmd.cnt_inc  = 1'b1;
                if (sts.cnt_last)
                begin
                    if (sts.mode == fltpm_pkg::MODE_MAP)
                        state_next = S_INST;
                    else
                    begin
                        cmd.set_st  = 1'b1;
                        cmd.st_code = fltpm_pkg::ST_OK;
                        state_next  = S_FIN;
                    end
                end
            end
            S_INST:
            begin
                cmd.mem_we    = 1'b1;
                cmd.addr_sel  = fltpm_pkg::ADDR_WALK;
                cmd.wd_sel    = fltpm_pkg::WD_TABLE;
                cmd.added_inc = 1'b1;
                cmd.cur_t     = 1'b1;
                cmd.lvl_inc   = 1'b1;
                state_next    = sts.lvl_two ? S_LEAF : S_RD;
            end
            S_LEAF:
            begin
                cmd.mem_we   = 1'b1;
                cmd.addr_sel = fltpm_pkg::ADDR_WALK;
                cmd.wd_sel   = fltpm_pkg::WD_LEAF;
                cmd.set_st   = 1'b1;
                cmd.st_code  = fltpm_pkg::ST_OK;
                state_next   = S_FIN;
            end
            S_CPRD:
            begin
                cmd.mem_re   = 1'b1;
                cmd.addr_sel = fltpm_pkg::ADDR_KRN;
                state_next   = S_CPWR;
            end
            S_CPWR:
            begin
                cmd.mem_we   = 1'b1;
                cmd.addr_sel = fltpm_pkg::ADDR_TBL;
                cmd.wd_sel   = fltpm_pkg::WD_COPY;
                cmd.cnt_inc  = 1'b1;
                if (sts.cnt_last)
                begin
                    cmd.set_st  = 1'b1;
                    cmd.st_code = fltpm_pkg::ST_OK;
                    state_next  = S_FIN;
                end
                else
                    state_next = S_CPRD;
            end
            S_FIN:
            begin
                if (!sts.out_busy)
                begin
                    cmd.res_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    a_accept_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> (state_reg == S_DISP))
        else $error("accepted transaction not dispatched");

    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !cmd.mem_we)
        else $error("table write while idle");

    a_copy_pair: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CPWR) |=> (state_reg == S_CPRD || state_reg == S_FIN))
        else $error("copy sequence broken");

endmodule

// File: sv/fltpm_dp.sv
// Datapath of the page table mapper: table memory, free bitmap, walk registers.
// Depends on fltpm_pkg; steered by fltpm_ctrl.
module fltpm_dp #(
    parameter int POOL_TABLES = fltpm_pkg::POOL_TABLES_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  fltpm_pkg::cmd_t                  cmd,
    output fltpm_pkg::sts_t                  sts,
    input  logic [1:0]                       mode,
    input  logic [5:0]                       table_id,
    input  logic [fltpm_pkg::FRAME_W-1:0]    phys_frame,
    input  logic [fltpm_pkg::VA_W-1:0]       virt_addr,
    input  logic [fltpm_pkg::FLAGS_W-1:0]    flags,
    input  logic [fltpm_pkg::FRAME_W-1:0]    pool_base_frame,
    input  logic [5:0]                       kernel_root,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [1:0]                       status,
    output logic [5:0]                       new_table,
    output logic [1:0]                       tables_added,
    output logic [fltpm_pkg::ENTRY_W-1:0]    leaf_entry
);

    localparam int TW    = (POOL_TABLES > 1) ? $clog2(POOL_TABLES) : 1;
    localparam int AW    = TW + fltpm_pkg::IDX_W;
    localparam int DEPTH = POOL_TABLES * (2 ** fltpm_pkg::IDX_W);
    localparam int EW    = fltpm_pkg::ENTRY_W;
    localparam int FW    = fltpm_pkg::FRAME_W;

    logic [EW-1:0]  mem [DEPTH];

    logic [1:0]     mode_reg;
    logic [5:0]     tid_reg;
    logic [FW-1:0]  pframe_reg;
    logic [fltpm_pkg::VA_W-1:0] va_reg;
    logic [fltpm_pkg::FLAGS_W-1:0] flags_reg;

    logic [POOL_TABLES-1:0] inuse_reg;
    logic [TW-1:0]  scan_reg, t_reg, cur_reg;
    logic [fltpm_pkg::IDX_W-1:0] cnt_reg;
    logic [1:0]     lvl_reg, added_reg, st_reg;
    logic [EW-1:0]  rdata_reg;

    logic           ovalid_reg;
    logic [1:0]     ost_reg, oadded_reg;
    logic [5:0]     ont_reg;
    logic [EW-1:0]  oleaf_reg;

    logic [31:0]    tid_w, kroot_w, t_w;
    logic [TW-1:0]  tid_ix, kroot_ix;
    logic [fltpm_pkg::IDX_W-1:0] lvl_ix;
    logic [FW-1:0]  off, new_frame;
    logic [EW-1:0]  tbl_entry, leaf_val, wdata;
    logic [AW-1:0]  addr;

    assign tid_w    = 32'(tid_reg);
    assign kroot_w  = 32'(kernel_root);
    assign t_w      = 32'(t_reg);
    assign tid_ix   = tid_w[TW-1:0];
    assign kroot_ix = kroot_w[TW-1:0];

    always_comb
    begin
        unique case (lvl_reg)
            2'd0:    lvl_ix = va_reg[fltpm_pkg::SH_L0 +: fltpm_pkg::IDX_W];
            2'd1:    lvl_ix = va_reg[fltpm_pkg::SH_L1 +: fltpm_pkg::IDX_W];
            2'd2:    lvl_ix = va_reg[fltpm_pkg::SH_L2 +: fltpm_pkg::IDX_W];
            default: lvl_ix = va_reg[fltpm_pkg::SH_L3 +: fltpm_pkg::IDX_W];
        endcase
    end

    assign off       = rdata_reg[fltpm_pkg::PAGE_SHIFT +: FW] - pool_base_frame;
    assign new_frame = pool_base_frame + FW'(t_reg);
    assign tbl_entry = ({{(EW-FW){1'b0}}, new_frame} << fltpm_pkg::PAGE_SHIFT)
                     | fltpm_pkg::BIT_PRESENT | fltpm_pkg::BIT_WRITE | EW'(flags_reg);
    assign leaf_val  = ({{(EW-FW){1'b0}}, pframe_reg} << fltpm_pkg::PAGE_SHIFT)
                     | fltpm_pkg::BIT_PRESENT | fltpm_pkg::BIT_WRITE | EW'(flags_reg);

    always_comb
    begin
        unique case (cmd.addr_sel)
            fltpm_pkg::ADDR_TBL: addr = {t_reg, cnt_reg};
            fltpm_pkg::ADDR_KRN: addr = {kroot_ix, cnt_reg};
            default:             addr = {cur_reg, lvl_ix};
        endcase
        unique case (cmd.wd_sel)
            fltpm_pkg::WD_TABLE: wdata = tbl_entry;
            fltpm_pkg::WD_LEAF:  wdata = leaf_val;
            fltpm_pkg::WD_COPY:  wdata = rdata_reg;
            default:             wdata = '0;
        endcase
    end

    // table memory: one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.mem_we)
            mem[addr] <= wdata;
        if (cmd.mem_re)
            rdata_reg <= mem[addr];
    end

    // request payload and walk registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            mode_reg   <= mode;
            tid_reg    <= table_id;
            pframe_reg <= phys_frame;
            va_reg     <= virt_addr;
            flags_reg  <= flags;
        end
        if (cmd.walk_init)
            cur_reg <= tid_ix;
        else if (cmd.cur_off)
            cur_reg <= off[TW-1:0];
        else if (cmd.cur_t)
            cur_reg <= t_reg;
        if (cmd.take)
            t_reg <= scan_reg;
        if (cmd.set_st)
            st_reg <= cmd.st_code;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inuse_reg  <= '0;
            scan_reg   <= '0;
            cnt_reg    <= '0;
            lvl_reg    <= '0;
            added_reg  <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.walk_init)
            begin
                scan_reg  <= '0;
                cnt_reg   <= '0;
                lvl_reg   <= '0;
                added_reg <= '0;
            end
            else
            begin
                if (cmd.scan_inc)
                    scan_reg <= scan_reg + 1'b1;
                if (cmd.cnt_inc)
                    cnt_reg <= cnt_reg + 1'b1;
                if (cmd.lvl_inc)
                    lvl_reg <= lvl_reg + 1'b1;
                if (cmd.added_inc)
                    added_reg <= added_reg + 1'b1;
            end
            if (cmd.take)
                inuse_reg[scan_reg] <= 1'b1;
            if (cmd.free)
                inuse_reg[tid_ix] <= 1'b0;
            if (cmd.res_load)
                ovalid_reg <= 1'b1;
            else if (out_ready)
                ovalid_reg <= 1'b0;
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (cmd.res_load)
        begin
            ost_reg    <= st_reg;
            oadded_reg <= (mode_reg == fltpm_pkg::MODE_MAP) ? added_reg : 2'd0;
            ont_reg    <= (st_reg == fltpm_pkg::ST_OK && (mode_reg == fltpm_pkg::MODE_COPY
                           || mode_reg == fltpm_pkg::MODE_ALLOC)) ? t_w[5:0] : 6'd0;
            oleaf_reg  <= (st_reg == fltpm_pkg::ST_OK && mode_reg == fltpm_pkg::MODE_MAP)
                          ? leaf_val : '0;
        end
    end

    assign sts.mode          = mode_reg;
    assign sts.tid_bad       = (32'(tid_reg) >= 32'(POOL_TABLES));
    assign sts.kroot_bad     = (32'(kernel_root) >= 32'(POOL_TABLES));
    assign sts.present       = rdata_reg[0];
    assign sts.off_bad       = (off >= FW'(POOL_TABLES));
    assign sts.scan_free     = !inuse_reg[scan_reg];
    assign sts.scan_last     = (scan_reg == TW'(POOL_TABLES - 1));
    assign sts.scan_is_kroot = (scan_reg == kroot_ix);
    assign sts.cnt_last      = (cnt_reg == {fltpm_pkg::IDX_W{1'b1}});
    assign sts.lvl_two       = (lvl_reg == 2'd2);
    assign sts.out_busy      = ovalid_reg && !out_ready;

    assign out_valid    = ovalid_reg;
    assign status       = ost_reg;
    assign new_table    = ont_reg;
    assign tables_added = oadded_reg;
    assign leaf_entry   = oleaf_reg;

endmodule

// File: sv/four_level_page_table_mapper.sv
// Four-level page table mapper top level: stream ports, APB registers, core.
// Depends on fltpm_pkg, fltpm_ctrl and fltpm_dp.
//
// One request at a time. A request passes accept, dispatch and result steps
// plus the following. Each level walked through an existing entry takes a
// read and an evaluate step. Each new table adds a read, an evaluate and an
// install step and zeroes all 512 entries of the table through the single
// memory write port. The free-bitmap search checks one bitmap entry per
// cycle. Within a request it resumes where the last take stopped, so one
// request scans at most about POOL_TABLES entries in all. A root copy runs
// the search, then a read and a write per entry on the one memory port. A
// map builds up to three new tables. Table memory holds no reset; the free
// bitmap clears on reset, so no init pass runs. The result register lets the
// next request be taken while a result waits.
module four_level_page_table_mapper #(
    parameter int POOL_TABLES = fltpm_pkg::POOL_TABLES_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    // s_axis_tdata: mode[1:0], table_id[7:2], phys_frame[47:8],
    //               virt_addr[95:48], flags[107:96], zero fill [111:108]
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [111:0] s_axis_tdata,
    // m_axis_tdata: status[1:0], new_table[7:2], tables_added[9:8],
    //               leaf_entry[73:10], zero fill [79:74]
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [79:0]  m_axis_tdata,
    // APB: pool_base_frame at 0x0, kernel_root at 0x8
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [63:0]  pwdata,
    output logic [63:0]  prdata,
    output logic         pready
);

    fltpm_pkg::cmd_t cmd;
    fltpm_pkg::sts_t sts;

    logic [fltpm_pkg::FRAME_W-1:0] base_reg;
    logic [5:0]                    kroot_reg;
    logic                          cfg_wr;

    logic [1:0]  status;
    logic [5:0]  new_table;
    logic [1:0]  tables_added;
    logic [63:0] leaf_entry;

    // register transaction: paddr[3] picks the register
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg  <= '0;
            kroot_reg <= '0;
        end
        else if (cfg_wr)
        begin
            if (paddr[3])
                kroot_reg <= pwdata[5:0];
            else
                base_reg <= pwdata[fltpm_pkg::FRAME_W-1:0];
        end
    end

    assign prdata = paddr[3] ? {58'd0, kroot_reg}
                             : {{(64 - fltpm_pkg::FRAME_W){1'b0}}, base_reg};

    fltpm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    fltpm_dp #(
        .POOL_TABLES (POOL_TABLES)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .sts             (sts),
        .mode            (s_axis_tdata[1:0]),
        .table_id        (s_axis_tdata[7:2]),
        .phys_frame      (s_axis_tdata[47:8]),
        .virt_addr       (s_axis_tdata[95:48]),
        .flags           (s_axis_tdata[107:96]),
        .pool_base_frame (base_reg),
        .kernel_root     (kroot_reg),
        .out_valid       (m_axis_tvalid),
        .out_ready       (m_axis_tready),
        .status          (status),
        .new_table       (new_table),
        .tables_added    (tables_added),
        .leaf_entry      (leaf_entry)
    );

    assign m_axis_tdata = {6'd0, leaf_entry, tables_added, new_table, status};

endmodule
